FILE: rtl/integer_to_radix_ascii_defines.svh
// Assertion macros shared by the integer to radix text converter RTL.
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define ITRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ITRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/itra_pkg.sv
// Shared constants and the digit-to-character function of the radix text converter.
package itra_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int RADIX_W         = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  // Map a digit 0..35 to '0'-'9' then 'A'-'Z'.
  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < RADIX_W'(10)) begin
      return CHAR_ZERO + d8;
    end else begin
      return CHAR_UPPER_A + d8 - 8'd10;
    end
  endfunction

endpackage

FILE: rtl/integer_to_radix_ascii.sv
// Integer to radix text converter: one input value becomes a run of ASCII characters.
// Each digit comes from one pass of the shared bit-serial divider, and the characters
// (sign and digits) are then emitted one per cycle when out_stall is low.
// A new value is accepted only once the last character of the previous one is issued.
// Reset (synchronous, active high) sets radix to 10 and returns the sequencer to idle.
`include "integer_to_radix_ascii_defines.svh"

module integer_to_radix_ascii
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   radix_wr_en,
  input  logic [RADIX_W-1:0]     radix_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             char_code,
  output logic                   last_char
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t                 state;
  logic [RADIX_W-1:0]     radix;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [CNT_W-1:0]       nd;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [RADIX_W-1:0]     div_rem;
  logic [RADIX_W-1:0]     digits [VALUE_WIDTH];
  logic                   out_free;
  logic                   push;
  logic                   pop;

  // Saturate base writes to the legal range.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (radix_wr_en) begin
      if (radix_wr_data < RADIX_MIN) begin
        radix <= RADIX_MIN;
      end else if (radix_wr_data > RADIX_MAX) begin
        radix <= RADIX_MAX;
      end else begin
        radix <= radix_wr_data;
      end
    end
  end

  itra_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (radix),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign push     = (state == S_DIV) && div_done;
  assign pop      = (state == S_EMIT) && out_free;

  // Hold digits in a stack: push least significant first, pop most significant first.
  always_ff @(posedge clk) begin
    if (push) begin
      digits[0] <= div_rem;
      for (int i = 1; i < VALUE_WIDTH; i++) begin
        digits[i] <= digits[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
        digits[i] <= digits[i+1];
      end
    end
  end

  // Sequence one value: divide repeatedly, then emit sign and digits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      nd        <= '0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg       <= value[VALUE_WIDTH-1];
            mag       <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
            nd        <= '0;
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            nd  <= nd + CNT_W'(1);
            mag <= div_quot;
            if (div_quot == '0 || nd == CNT_W'(VALUE_WIDTH - 1)) begin
              state <= neg ? S_SIGN : S_EMIT;
            end else begin
              div_start <= 1'b1;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            char_code <= CHAR_MINUS;
            last_char <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            char_code <= digit_char(digits[0]);
            last_char <= (nd == CNT_W'(1));
            nd        <= nd - CNT_W'(1);
            if (nd == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ITRA_ASSERT(a_radix_range, (radix >= RADIX_MIN && radix <= RADIX_MAX), "radix out of range")
  `ITRA_ASSERT(a_digit_count, (nd <= CNT_W'(VALUE_WIDTH)), "digit count overflow")
  `ITRA_ASSERT(a_rem_below_radix, (push |-> div_rem < radix), "remainder not below radix")
  `ITRA_ASSERT(a_done_in_div, (div_done |-> state == S_DIV), "divider finished outside divide")
  `ITRA_ASSERT(a_pop_nonempty, (pop |-> nd != '0), "pop from empty digit stack")

endmodule

FILE: rtl/itra_div.sv
// Bit-serial restoring divider: VALUE_WIDTH-bit dividend by a 6-bit divisor.
module itra_div
  import itra_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [RADIX_W-1:0]     divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quot,
  output logic [RADIX_W-1:0]     rem
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [CNT_W-1:0] cnt;
  logic [RADIX_W:0] trial;
  logic [RADIX_W:0] diff;
  logic             ge;

  // Shift the next dividend bit into the partial remainder and compare.
  assign trial = {rem, quot[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // Load on start, then retire one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        rem  <= '0;
        cnt  <= CNT_W'(VALUE_WIDTH);
      end else if (cnt != '0) begin
        rem  <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
        quot <= {quot[VALUE_WIDTH-2:0], ge};
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the integer to radix text converter.
`timescale 1ns / 1ps

module testbench;
  import itra_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int STUCK_LIMIT = 12000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 40;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Predicts the character run of every accepted value and checks the run that comes out.
  class radix_text_board;
    logic [RADIX_W-1:0] radix_now;
    text_char_t         chars_due[$];
    int unsigned        mismatches;

    function new();
      radix_now  = RADIX_RESET;
      mismatches = 0;
    endfunction

    // Clamp a register write to the legal base range.
    function void set_radix(input logic [RADIX_W-1:0] wr_data);
      if (wr_data < RADIX_MIN) begin
        radix_now = RADIX_MIN;
      end else if (wr_data > RADIX_MAX) begin
        radix_now = RADIX_MAX;
      end else begin
        radix_now = wr_data;
      end
    endfunction

    function int pending();
      return chars_due.size();
    endfunction

    // Spell one accepted value and queue its characters.
    function void note_value(input logic [VW-1:0] v);
      logic [VW-1:0] mag;
      logic [VW-1:0] base;
      logic [7:0]    digit;
      text_char_t    c;
      text_char_t    spelled[$];
      base = VW'(radix_now);
      // The magnitude of the most negative value wraps to itself as unsigned.
      mag = v[VW-1] ? -v : v;
      do begin
        digit  = 8'(mag % base);
        c.code = (digit < 8'd10) ? CHAR_ZERO + digit : CHAR_UPPER_A + digit - 8'd10;
        c.last = 1'b0;
        spelled.push_front(c);
        mag = mag / base;
      end while (mag != 0);
      if (v[VW-1]) begin
        c.code = CHAR_MINUS;
        c.last = 1'b0;
        spelled.push_front(c);
      end
      // Flag the final character of the run.
      c = spelled[spelled.size()-1];
      c.last = 1'b1;
      spelled[spelled.size()-1] = c;
      foreach (spelled[i]) chars_due.push_back(spelled[i]);
    endfunction

    // Compare one output transaction against the oldest queued character.
    function void check_char(input logic [7:0] code, input logic last);
      text_char_t want;
      if (chars_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: character %h last %b arrived with none queued", $realtime, code, last);
        return;
      end
      want = chars_due.pop_front();
      if (code !== want.code || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected char %h last %b, got char %h last %b",
                   $realtime, want.code, want.last, code, last);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                radix_wr_en = 1'b0;
  logic [RADIX_W-1:0]  radix_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VW-1:0]       value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          char_code;
  logic                last_char;
  logic                calm = 1'b0;
  int unsigned         stuck_cycles = 0;
  radix_text_board     board;

  integer_to_radix_ascii #(
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .radix_wr_en  (radix_wr_en),
    .radix_wr_data(radix_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_code    (char_code),
    .last_char    (last_char)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Stall the output at random unless in a calm stretch.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 13);
  end

  // Check every accepted output transaction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_char(char_code, last_char);
    end
  end

  // Abort when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || radix_wr_en) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Send one value, with random gaps; starts and ends at a falling edge.
  task automatic convert(input logic [VW-1:0] v);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    value    = v;
    do @(posedge clk); while (in_stall);
    board.note_value(v);
    @(negedge clk);
  endtask

  // Drain all queued characters, then write the base register.
  task automatic set_radix(input logic [RADIX_W-1:0] wr_data);
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    radix_wr_en   = 1'b1;
    radix_wr_data = wr_data;
    @(posedge clk);
    board.set_radix(wr_data);
    @(negedge clk);
    radix_wr_en = 1'b0;
  endtask

  // Draw a value: raw bits, small magnitudes, powers of the base, shifted words, extremes.
  function automatic logic [VW-1:0] pick_value(input int unsigned r);
    logic [63:0]   p;
    logic [VW-1:0] v;
    int unsigned   k;
    int            kind;
    kind = $urandom_range(0, 5);
    case (kind)
      2: v = VW'($urandom_range(0, 2 * r));
      3: begin
        p = 1;
        k = $urandom_range(1, VW);
        repeat (k) begin
          if (p * r <= (64'd1 << (VW - 1))) p = p * r;
        end
        v = VW'(p) - VW'($urandom_range(0, 1));
      end
      4: v = VW'($urandom()) >> $urandom_range(0, VW - 1);
      5: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = {1'b0, {(VW-1){1'b1}}};
          2:       v = {1'b1, {(VW-1){1'b0}}};
          default: v = '1;
        endcase
      end
      default: v = VW'($urandom());
    endcase
    if (kind >= 2 && kind <= 4 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset base: zero, one, minus one, both extremes, a long decimal.
    convert('0);
    convert(VW'(1));
    convert('1);
    convert({1'b0, {(VW-1){1'b1}}});
    convert({1'b1, {(VW-1){1'b0}}});
    convert(VW'(1234567890));

    // Write below the range: base two, longest runs.
    set_radix('0);
    convert({1'b1, {(VW-1){1'b0}}});
    convert('1);
    convert({1'b0, {(VW-1){1'b1}}});
    convert('0);

    // Write above the range: base thirty-six, top digit and digit rollover.
    set_radix('1);
    convert(VW'(35));
    convert(VW'(36));
    convert(-VW'(36));
    convert({1'b1, {(VW-1){1'b0}}});
    convert({1'b0, {(VW-1){1'b1}}});

    set_radix(RADIX_W'(1));
    convert(VW'(6));
    set_radix(RADIX_W'(37));
    convert(-VW'(1295));
    set_radix(RADIX_W'(16));
    convert(VW'(32'hDEADBEEF));
    convert(VW'(32'h0000FFFF));
    set_radix(RADIX_MAX);
    convert(VW'(46655));
    set_radix(RADIX_MIN);
    convert(VW'(3));

    // Random phases, each under its own base; one runs without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      if ($urandom_range(0, 1) == 1) begin
        set_radix(RADIX_W'($urandom_range(2, 36)));
      end else begin
        set_radix(RADIX_W'($urandom_range(0, 63)));
      end
      calm = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        convert(pick_value(board.radix_now));
      end
    end
    calm     = 1'b0;
    in_valid = 1'b0;

    // Hold until every character is back, then watch for strays.
    while (board.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/itra_pkg.sv
rtl/itra_div.sv
rtl/integer_to_radix_ascii.sv
tb/testbench.sv
